[hw/rtl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stream find-and-replace block
// Register indexes, the queued result entry and the queue cell controls.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned LEN_W      = 4;

	typedef logic [7:0]           byte_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PATTERN_BYTES = 2'd0;
	localparam cfg_idx_t REG_PATTERN_LEN   = 2'd1;
	localparam cfg_idx_t REG_REPLACE_BYTES = 2'd2;
	localparam cfg_idx_t REG_REPLACE_LEN   = 2'd3;

	// one result as it waits in the output queue
	typedef struct packed {
		byte_t data;
		logic  byte_valid;
		logic  last;
	} entry_t;

	// per-cell control of the output queue
	typedef struct packed {
		logic take_nbr;
		logic take_new;
	} qctl_t;

endpackage

[hw/rtl/stream_find_replace.sv]
// ----------------------------------------------------------------------------
// stream_find_replace: streaming find-and-replace over a byte stream
// Path: a request's result list is registered in stage 1, then queued.
// Throughput: one request per cycle while each request yields at most one
//   result and out_stall is low; the queue drains one result per cycle, so
//   bursts of replacement or flush bytes hold in_stall until it has room.
// Reset: asynchronous; clears window, queue and registers to their defaults.
// ----------------------------------------------------------------------------
module stream_find_replace #(
	parameter int unsigned MAX_PATTERN = 8,
	parameter int unsigned MAX_REPLACE = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_write,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        in_byte,
	input  logic                              in_last,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        out_byte,
	output logic                              byte_valid,
	output logic                              out_last
);

	// window positions: held bytes plus the byte of the current request
	localparam int unsigned WIN  = MAX_PATTERN;
	// most results one request can cause (a bare end marker needs one)
	localparam int unsigned LIST = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
	// queue deep enough to take a full list while another one waits
	localparam int unsigned QD   = 2 * LIST;
	localparam int unsigned NW   = $clog2(WIN + 1);
	localparam int unsigned CW   = $clog2(LIST + 1);
	localparam int unsigned QW   = $clog2(QD + 1);
	localparam int unsigned LW   = sfr_pkg::LEN_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [sfr_pkg::CFG_DATA_W-1:0] pattern_q;
	logic [LW-1:0]                  pat_len_q;
	logic [sfr_pkg::CFG_DATA_W-1:0] replace_q;
	logic [LW-1:0]                  rep_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			pat_len_q <= LW'(1);
			replace_q <= '0;
			rep_len_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				sfr_pkg::REG_PATTERN_BYTES: pattern_q <= cfg_data;
				sfr_pkg::REG_PATTERN_LEN:   pat_len_q <= cfg_data[LW-1:0];
				sfr_pkg::REG_REPLACE_BYTES: replace_q <= cfg_data;
				sfr_pkg::REG_REPLACE_LEN:   rep_len_q <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// Effective lengths: a zero pattern length counts as one, both saturate.
	logic [NW-1:0] eff_pat;
	logic [CW-1:0] eff_rep;

	always_comb begin
		if (pat_len_q == '0) begin
			eff_pat = NW'(1);
		end else if (pat_len_q > LW'(MAX_PATTERN)) begin
			eff_pat = NW'(MAX_PATTERN);
		end else begin
			eff_pat = NW'(pat_len_q);
		end
		if (rep_len_q > LW'(MAX_REPLACE)) begin
			eff_rep = CW'(MAX_REPLACE);
		end else begin
			eff_rep = CW'(rep_len_q);
		end
	end

	// ------------------------------------------------------------------
	// Match window: a row of cells, each holding one byte and comparing it
	// against every pattern byte. Positions below held_cnt_q show held
	// bytes; the next position shows the byte of the incoming request.
	// ------------------------------------------------------------------
	logic                in_acc;
	logic [NW-1:0]       held_cnt_q;
	logic [NW-1:0]       held_cnt_nxt;
	logic [NW-1:0]       n;
	sfr_pkg::byte_t      pat_b   [WIN];
	sfr_pkg::byte_t      win_b   [WIN];
	sfr_pkg::byte_t      win_nxt [WIN];
	logic [WIN-1:0]      eq      [WIN];

	assign in_acc = in_valid && !in_stall;
	assign n      = held_cnt_q + NW'(1);

	for (genvar j = 0; j < WIN; j++) begin : g_win
		assign pat_b[j] = pattern_q[8*j +: 8];

		sfr_win_cell #(
			.NUM_CMP(WIN)
		) u_cell (
			.clk      (clk),
			.load     (in_acc),
			.load_byte(win_nxt[j]),
			.in_byte  (in_byte),
			.use_held (NW'(j) < held_cnt_q),
			.pat_byte (pat_b),
			.cur_byte (win_b[j]),
			.eq       (eq[j])
		);
	end

	// For each start position, check whether the bytes from there to the end
	// of the window are a prefix of the pattern no longer than the pattern.
	// The first start that passes keeps its tail; the bytes ahead of it can
	// no longer begin a match and go out.
	logic [WIN-1:0] pref;
	logic [NW-1:0]  start;
	logic           match;

	always_comb begin
		for (int s = 0; s < WIN; s++) begin
			pref[s] = (int'(n) - s) <= int'(eff_pat);
			for (int i = 0; i < WIN - s; i++) begin
				if ((s + i) < int'(n) && !eq[s + i][i]) begin
					pref[s] = 1'b0;
				end
			end
		end
		start = n;
		for (int s = WIN - 1; s >= 0; s--) begin
			if (s < int'(n) && pref[s]) begin
				start = NW'(s);
			end
		end
	end

	assign match = ((n - start) == eff_pat);

	// Build the result list of this request: dropped bytes, then either the
	// replacement or (at end of stream) the rest of the window.
	sfr_pkg::entry_t list     [LIST];
	logic [CW-1:0]   cnt;

	always_comb begin
		logic [2:0] off;
		off = '0;
		if (match) begin
			cnt = CW'(start) + eff_rep;
		end else if (in_last) begin
			cnt = CW'(n);
		end else begin
			cnt = CW'(start);
		end
		for (int k = 0; k < LIST; k++) begin
			list[k].data       = win_b[(k < WIN) ? k : 0];
			list[k].byte_valid = 1'b1;
			list[k].last       = in_last && (k == int'(cnt) - 1);
			if (match && k >= int'(start)) begin
				off          = 3'(k - int'(start));
				list[k].data = replace_q[{off, 3'b000} +: 8];
			end
		end
		// empty end of stream: send a bare end marker
		if (in_last && cnt == '0) begin
			cnt                = CW'(1);
			list[0].data       = '0;
			list[0].byte_valid = 1'b0;
			list[0].last       = 1'b1;
		end
	end

	// Advance the window: keep the tail from the start position on, or drop
	// everything after a replacement or at end of stream.
	always_comb begin
		if (in_last || match) begin
			held_cnt_nxt = '0;
		end else begin
			held_cnt_nxt = n - start;
		end
		for (int j = 0; j < WIN; j++) begin
			win_nxt[j] = win_b[j];
		end
		for (int s = 0; s < WIN; s++) begin
			for (int j = 0; j < WIN - s; j++) begin
				if (start == NW'(s)) begin
					win_nxt[j] = win_b[s + j];
				end
			end
		end
	end

	// Rewriting the pattern length discards the held window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
		end else if (cfg_write && cfg_index == sfr_pkg::REG_PATTERN_LEN) begin
			held_cnt_q <= '0;
		end else if (in_acc) begin
			held_cnt_q <= held_cnt_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: register the result list of the accepted request
	// ------------------------------------------------------------------
	sfr_pkg::entry_t list_s1 [LIST];
	logic [CW-1:0]   cnt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
		end else if (in_acc) begin
			cnt_s1 <= cnt;
		end else begin
			cnt_s1 <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			list_s1 <= list;
		end
	end

	// ------------------------------------------------------------------
	// Output queue: a row of cells, cell 0 drives the port. On a pop every
	// occupied cell takes its neighbor; the new list lands in the free
	// cells right behind the occupied ones.
	// ------------------------------------------------------------------
	logic [QW-1:0]   qcnt_q;
	logic [QW-1:0]   base;
	logic [QW:0]     occ;
	logic            pop;
	sfr_pkg::entry_t q_e   [QD];
	sfr_pkg::entry_t nbr_e [QD];
	sfr_pkg::entry_t new_e [QD];
	sfr_pkg::qctl_t  ctl   [QD];

	assign pop  = (qcnt_q != '0) && !out_stall;
	assign base = qcnt_q - QW'(pop);

	for (genvar i = 0; i < QD; i++) begin : g_q
		if (i + 1 < QD) begin : g_nbr
			assign nbr_e[i] = q_e[i + 1];
		end else begin : g_tail
			assign nbr_e[i] = '0;
		end

		always_comb begin
			ctl[i].take_nbr = pop && (QW'(i) < base);
			ctl[i].take_new = (QW'(i) >= base) && (QW'(i) < base + QW'(cnt_s1));
			new_e[i]        = '0;
			for (int k = 0; k < LIST; k++) begin
				if (i - int'(base) == k) begin
					new_e[i] = list_s1[k];
				end
			end
		end

		sfr_out_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.nbr      (nbr_e[i]),
			.new_entry(new_e[i]),
			.entry    (q_e[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
		end else begin
			qcnt_q <= base + QW'(cnt_s1);
		end
	end

	// Hold requests unless the queue can take a full list on top of what
	// is queued and what waits in stage 1.
	assign occ      = {1'b0, qcnt_q} + (QW + 1)'(cnt_s1);
	assign in_stall = occ > (QW + 1)'(QD - LIST);

	assign out_valid  = (qcnt_q != '0);
	assign out_byte   = q_e[0].data;
	assign byte_valid = q_e[0].byte_valid;
	assign out_last   = q_e[0].last;

endmodule

[hw/rtl/sfr_win_cell.sv]
// ----------------------------------------------------------------------------
// sfr_win_cell: one position of the match window
// Holds one window byte, stands in the new byte past the held ones and
// compares its byte with every pattern byte.
// ----------------------------------------------------------------------------
module sfr_win_cell #(
	parameter int unsigned NUM_CMP = 8
) (
	input  logic          clk,
	input  logic          load,
	input  sfr_pkg::byte_t load_byte,
	input  sfr_pkg::byte_t in_byte,
	input  logic          use_held,
	input  sfr_pkg::byte_t pat_byte [NUM_CMP],
	output sfr_pkg::byte_t cur_byte,
	output logic [NUM_CMP-1:0] eq
);

	sfr_pkg::byte_t held_q;

	always_ff @(posedge clk) begin
		if (load) begin
			held_q <= load_byte;
		end
	end

	assign cur_byte = use_held ? held_q : in_byte;

	always_comb begin
		for (int k = 0; k < NUM_CMP; k++) begin
			eq[k] = (cur_byte == pat_byte[k]);
		end
	end

endmodule

[hw/rtl/sfr_out_cell.sv]
// ----------------------------------------------------------------------------
// sfr_out_cell: one slot of the output queue
// Takes the entry of its neighbor when the queue advances, or a fresh entry
// when it is among the free slots the new list fills, and holds otherwise.
// ----------------------------------------------------------------------------
module sfr_out_cell (
	input  logic            clk,
	input  sfr_pkg::qctl_t  ctl,
	input  sfr_pkg::entry_t nbr,
	input  sfr_pkg::entry_t new_entry,
	output sfr_pkg::entry_t entry
);

	sfr_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.take_nbr) begin
			entry_q <= nbr;
		end else if (ctl.take_new) begin
			entry_q <= new_entry;
		end
	end

	assign entry = entry_q;

endmodule

[sim/tb_stream_find_replace.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_find_replace: self-checking bench for the stream find-and-replace
// Streams of text bytes are driven into the block under bursty traffic while
// the output side stalls on its own pattern. A shadow copy of the window and
// the registers predicts every output byte, and each one is compared in order.
// ----------------------------------------------------------------------------
module tb_stream_find_replace;

	localparam int unsigned CLK_HALF     = 6;
	localparam int unsigned RESET_CYCLES = 12;
	// settle time once every request is taken and every result is back
	localparam int unsigned DRAIN_CYCLES = 10;
	// long output hold-off that backs the block up into in_stall
	localparam int unsigned CHOKE_CYCLES = 160;
	// cycles without any accepted request or result before giving up
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned PHASES       = 12;
	localparam int unsigned PHASE_ITEMS  = 25;

	typedef struct {
		sfr_pkg::byte_t data;
		logic           last;
	} text_req_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BEAT
	} stall_mode_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           cfg_write = 1'b0;
	sfr_pkg::cfg_idx_t              cfg_index = sfr_pkg::REG_PATTERN_BYTES;
	logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	logic [7:0]                     in_byte   = 8'h00;
	logic                           in_last   = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [7:0]                     out_byte;
	logic                           byte_valid;
	logic                           out_last;

	// shadow registers, at their reset values
	logic [63:0] pat_word = '0;
	logic [3:0]  pat_len  = 4'd1;
	logic [63:0] rep_word = '0;
	logic [3:0]  rep_len  = 4'd0;
	// shadow window of bytes that may still begin a match
	sfr_pkg::byte_t held_bytes [0:6];
	int unsigned    held_n = 0;

	sfr_pkg::entry_t text_due [$];      // output bytes still owed by the block
	text_req_t       text_pending [$];  // requests not yet offered to the block
	int              err_count = 0;

	logic        in_took = 1'b0;    // request accepted at the last rising edge
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_tick = 0;
	int unsigned choke_ask = 0;
	int unsigned choke_seen = 0;
	int unsigned choke_left = 0;

	int unsigned idle_cycles = 0;

	stream_find_replace u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		err_count++;
	endtask

	// a zero length behaves as one byte, anything past eight as eight
	function automatic int unsigned eff_pat_len(input logic [3:0] l);
		if (l == 4'd0)
			return 1;
		if (l > 4'd8)
			return 8;
		return 32'(l);
	endfunction

	function automatic sfr_pkg::entry_t text_entry(input sfr_pkg::byte_t b, input logic v);
		return {b, v, 1'b0};
	endfunction

	// Advance the shadow window by one text byte and queue the output it causes.
	task automatic replace_step(input sfr_pkg::byte_t b, input logic last);
		sfr_pkg::byte_t  win [0:7];
		sfr_pkg::entry_t outs [0:8];
		int unsigned     plen, rlen, n, start, len, i, k;
		logic            pref, done;
		plen  = eff_pat_len(pat_len);
		rlen  = (rep_len > 4'd8) ? 8 : 32'(rep_len);
		n     = held_n;
		start = 0;
		k     = 0;
		for (i = 0; i < n; i++)
			win[i] = held_bytes[i];
		win[n] = b;
		n++;
		// drop leading bytes until what is left could still grow into the pattern
		done = 1'b0;
		while (!done && start < n) begin
			len  = n - start;
			pref = (len <= plen);
			for (i = 0; pref && i < len; i++) begin
				if (win[start + i] != pat_word[8*i +: 8])
					pref = 1'b0;
			end
			if (pref) begin
				done = 1'b1;
			end else begin
				outs[k] = text_entry(win[start], 1'b1);
				k++;
				start++;
			end
		end
		// full match: swap in the replacement, never rescanned
		if (n - start == plen) begin
			for (i = 0; i < rlen; i++) begin
				outs[k] = text_entry(rep_word[8*i +: 8], 1'b1);
				k++;
			end
			start = n;
		end
		if (last) begin
			// flush whatever is held; an empty end still gets a bare marker
			while (start < n) begin
				outs[k] = text_entry(win[start], 1'b1);
				k++;
				start++;
			end
			if (k == 0) begin
				outs[k] = text_entry(8'h00, 1'b0);
				k++;
			end
			outs[k-1].last = 1'b1;
			held_n = 0;
		end else begin
			held_n = n - start;
			for (i = 0; i < held_n; i++)
				held_bytes[i] = win[start + i];
		end
		for (i = 0; i < k; i++)
			text_due.push_back(outs[i]);
	endtask

	// Monitor: track register writes and requests, check every result in order.
	always @(posedge clk) begin : monitor
		sfr_pkg::entry_t want;
		in_took <= in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					sfr_pkg::REG_PATTERN_BYTES: pat_word = cfg_data;
					sfr_pkg::REG_PATTERN_LEN: begin
						// a new length throws the held window away
						pat_len = cfg_data[3:0];
						held_n  = 0;
					end
					sfr_pkg::REG_REPLACE_BYTES: rep_word = cfg_data;
					sfr_pkg::REG_REPLACE_LEN:   rep_len  = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				replace_step(in_byte, in_last);
			if (out_valid && !out_stall) begin
				if (text_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result byte %02h valid %b last %b",
						out_byte, byte_valid, out_last));
				end else begin
					want = text_due.pop_front();
					if (out_byte !== want.data)
						flag_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.data));
					if (byte_valid !== want.byte_valid)
						flag_mismatch($sformatf("byte_valid %b, expected %b",
							byte_valid, want.byte_valid));
					if (out_last !== want.last)
						flag_mismatch($sformatf("out_last %b, expected %b",
							out_last, want.last));
				end
			end
		end
	end

	// Driver: offer requests in bursts with random gaps; hold a stalled request.
	always @(negedge clk) begin : driver
		text_req_t req;
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (text_pending.size() != 0) begin
				req = text_pending.pop_front();
				in_valid <= 1'b1;
				in_byte  <= req.data;
				in_last  <= req.last;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					// roughly a third of the bursts run straight into the next one
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: draw a new random stall pattern periodically; serve choke requests.
	always @(negedge clk) begin : receiver
		stall_tick++;
		if (stall_tick % 64 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		if (choke_left != 0) begin
			out_stall <= 1'b1;
			choke_left--;
		end else if (choke_seen != choke_ask) begin
			choke_seen = choke_ask;
			choke_left = CHOKE_CYCLES;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= (stall_tick % 3 == 0);
			endcase
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	task automatic cfg_put(input sfr_pkg::cfg_idx_t idx, input logic [63:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		#1;
	endtask

	task automatic push_text(input sfr_pkg::byte_t b, input logic last);
		text_req_t req;
		req.data = b;
		req.last = last;
		text_pending.push_back(req);
	endtask

	// Hold until every request is taken and every result is back, then drain.
	task automatic wait_idle();
		@(posedge clk);
		#1;
		while (text_pending.size() != 0 || in_valid || text_due.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		#1;
	endtask

	// Queue one stream built mostly from pattern copies and prefixes.
	task automatic build_stream(input int unsigned nbytes, input logic close);
		sfr_pkg::byte_t text [$];
		int unsigned    plen, cut, i;
		sfr_pkg::byte_t tweak;
		plen = eff_pat_len(pat_len);
		while (text.size() < nbytes) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					for (i = 0; i < plen; i++)
						text.push_back(pat_word[8*i +: 8]);
				end
				4, 5: begin
					cut = $urandom_range(1, plen);
					for (i = 0; i < cut; i++)
						text.push_back(pat_word[8*i +: 8]);
				end
				6: begin
					// near miss: spoil the final byte of a copy
					tweak = sfr_pkg::byte_t'($urandom_range(1, 255));
					for (i = 0; i < plen; i++)
						text.push_back(pat_word[8*i +: 8] ^ ((i == plen - 1) ? tweak : 8'h00));
				end
				7: text.push_back(sfr_pkg::byte_t'($urandom_range(0, 255)));
				default: begin
					cut = $urandom_range(0, plen - 1);
					text.push_back(pat_word[8*cut +: 8]);
				end
			endcase
		end
		for (i = 0; i < nbytes; i++)
			push_text(text[i], close && (i == nbytes - 1));
	endtask

	initial begin : stimulus
		int unsigned    phase, items, nb, i;
		logic [63:0]    v;
		logic           close;
		sfr_pkg::byte_t letter_a, letter_b;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		#1;

		// Reset settings: one zero byte is deleted wherever it appears.
		push_text(8'h00, 1'b0);
		push_text(8'hFF, 1'b1);
		// a stream that deletes down to nothing ends on a bare marker
		push_text(8'h00, 1'b1);
		wait_idle();

		// Full-width pattern and replacement: one match yields eight bytes.
		cfg_put(sfr_pkg::REG_PATTERN_BYTES, 64'h8877_6655_4433_2211);
		cfg_put(sfr_pkg::REG_PATTERN_LEN, 64'd8);
		cfg_put(sfr_pkg::REG_REPLACE_BYTES, 64'hF0E1_D2C3_B4A5_9687);
		cfg_put(sfr_pkg::REG_REPLACE_LEN, 64'd8);
		for (i = 0; i < 8; i++)
			push_text(sfr_pkg::byte_t'(8'h11 * (i + 1)), i == 7);
		wait_idle();

		// Pattern length zero acts as one; an oversize replacement length saturates.
		// The upper data bits must be ignored.
		cfg_put(sfr_pkg::REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFF0);
		cfg_put(sfr_pkg::REG_REPLACE_LEN, 64'd15);
		push_text(8'h11, 1'b0);
		push_text(8'h7F, 1'b1);
		wait_idle();

		// Oversize pattern length saturates to eight. Leave three bytes held,
		// then rewrite the pattern so the held bytes get rechecked.
		cfg_put(sfr_pkg::REG_PATTERN_LEN, 64'd12);
		cfg_put(sfr_pkg::REG_REPLACE_LEN, 64'd2);
		push_text(8'h11, 1'b0);
		push_text(8'h22, 1'b0);
		push_text(8'h33, 1'b0);
		wait_idle();
		cfg_put(sfr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0044_3322);
		push_text(8'h44, 1'b0);
		push_text(8'h00, 1'b1);
		wait_idle();

		// Rewriting the pattern length with bytes held discards them.
		cfg_put(sfr_pkg::REG_PATTERN_LEN, 64'd3);
		push_text(8'h22, 1'b0);
		push_text(8'h33, 1'b0);
		wait_idle();
		cfg_put(sfr_pkg::REG_PATTERN_LEN, 64'd3);
		push_text(8'h44, 1'b1);
		wait_idle();

		// Random phases, each with its own settings, the first two at the extremes.
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				cfg_put(sfr_pkg::REG_PATTERN_BYTES, '1);
				cfg_put(sfr_pkg::REG_PATTERN_LEN, 64'd8);
				cfg_put(sfr_pkg::REG_REPLACE_BYTES, '0);
				cfg_put(sfr_pkg::REG_REPLACE_LEN, 64'd8);
			end else if (phase == 1) begin
				cfg_put(sfr_pkg::REG_PATTERN_BYTES, '0);
				cfg_put(sfr_pkg::REG_PATTERN_LEN, 64'd1);
				cfg_put(sfr_pkg::REG_REPLACE_BYTES, '1);
				cfg_put(sfr_pkg::REG_REPLACE_LEN, 64'd8);
			end else begin
				// draw the pattern from two letters so it often overlaps itself
				letter_a = sfr_pkg::byte_t'($urandom_range(0, 255));
				letter_b = sfr_pkg::byte_t'($urandom_range(0, 255));
				for (i = 0; i < 8; i++) begin
					case ($urandom_range(0, 4))
						0, 1:    v[8*i +: 8] = letter_a;
						2, 3:    v[8*i +: 8] = letter_b;
						default: v[8*i +: 8] = sfr_pkg::byte_t'($urandom_range(0, 255));
					endcase
				end
				if ($urandom_range(0, 3) != 0)
					cfg_put(sfr_pkg::REG_PATTERN_BYTES, v);
				if ($urandom_range(0, 3) != 0) begin
					v = {$urandom, $urandom};
					v[3:0] = ($urandom_range(0, 7) == 0) ?
						(($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15))) :
						4'($urandom_range(1, 8));
					cfg_put(sfr_pkg::REG_PATTERN_LEN, v);
				end
				if ($urandom_range(0, 3) != 0)
					cfg_put(sfr_pkg::REG_REPLACE_BYTES, {$urandom, $urandom});
				if ($urandom_range(0, 3) != 0) begin
					v = {$urandom, $urandom};
					v[3:0] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) :
						4'($urandom_range(0, 8));
					cfg_put(sfr_pkg::REG_REPLACE_LEN, v);
				end
			end

			// choke the output while the sender keeps offering requests
			if (phase == 1 || phase == 8)
				choke_ask++;

			items = 0;
			while (items < PHASE_ITEMS) begin
				nb = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 12);
				// now and then leave the final stream of a phase open across a rewrite
				close = !(items + nb >= PHASE_ITEMS && $urandom_range(0, 3) == 0);
				build_stream(nb, close);
				items += nb;
			end
			wait_idle();
		end

		// close any stream still open so the window ends empty
		push_text(sfr_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
		wait_idle();

		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
